// File: hw/rtl/intel_hex_record_decoder_unit_assert.svh
// Assertion macros for the Intel HEX decoder checker
`ifndef INTEL_HEX_RECORD_DECODER_UNIT_ASSERT_SVH
`define INTEL_HEX_RECORD_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define IHEXD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ihexd assertion failed");

// Next-cycle implication, disabled while in reset
`define IHEXD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ihexd assertion failed");

`endif

// File: hw/rtl/ihexd_pkg.sv
// Types, codes and helpers shared by the Intel HEX record decoder
`default_nettype none

package ihexd_pkg;

	// Character codes
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Record types of interest
	localparam logic [2:0] REC_DATA       = 3'd0;
	localparam logic [2:0] REC_EXT_LINEAR = 3'd4;
	localparam logic [7:0] REC_TYPE_MAX   = 8'd7;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  rtype;
		logic [31:0] addr;
		logic [7:0]  idx;
		logic [7:0]  data;
		logic [7:0]  len;
		logic        csum_ok;
		logic        trunc;
	} result_t;

	// ASCII hex digit to nibble; ok is low for any other character
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		logic [7:0] diff;
		d    = '0;
		diff = '0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			diff = c - CHAR_0;
			d.ok = 1'b1;
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			diff = c - (CHAR_UA - 8'd10);
			d.ok = 1'b1;
		end else if (c >= CHAR_LA && c <= CHAR_LF) begin
			diff = c - (CHAR_LA - 8'd10);
			d.ok = 1'b1;
		end
		d.val = diff[3:0];
		return d;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ihexd_core.sv
// Record parser state and per-character decode logic
`default_nettype none

module ihexd_core import ihexd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] char_in,
	output logic            emit,
	output result_t         res
);

	typedef enum logic [3:0] {
		PH_WAIT     = 4'd0,
		PH_CNT_HI   = 4'd1,
		PH_CNT_LO   = 4'd2,
		PH_ADRH_HI  = 4'd3,
		PH_ADRH_LO  = 4'd4,
		PH_ADRL_HI  = 4'd5,
		PH_ADRL_LO  = 4'd6,
		PH_TYPE_HI  = 4'd7,
		PH_TYPE_LO  = 4'd8,
		PH_DATA_HI  = 4'd9,
		PH_DATA_LO  = 4'd10
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  hold_q, hold_n;
	logic [7:0]  dcnt_q, dcnt_n;
	logic [7:0]  rcnt_q, rcnt_n;
	logic [31:0] addr_q, addr_n;
	logic [2:0]  type_q, type_n;
	logic [7:0]  sum_q, sum_n;
	logic [15:0] ftb_q, ftb_n;

	hex_digit_t  dig;
	logic [7:0]  byte_val;
	logic [7:0]  sum_add;
	logic        has_end;

	assign dig      = hex_decode(char_in);
	assign byte_val = {hold_q, dig.val};
	assign sum_add  = sum_q + byte_val;
	// empty data records close without an end transaction
	assign has_end  = !(rcnt_q == 8'd0 && type_q == REC_DATA);

	// Next state and result
	always_comb begin
		phase_n = phase_q;
		hold_n  = hold_q;
		dcnt_n  = dcnt_q;
		rcnt_n  = rcnt_q;
		addr_n  = addr_q;
		type_n  = type_q;
		sum_n   = sum_q;
		ftb_n   = ftb_q;
		emit    = 1'b0;
		res     = '0;
		res.rtype = type_q;
		res.addr  = addr_q;
		res.len   = rcnt_q;
		res.kind  = KIND_END;

		if (char_in == CHAR_COLON) begin
			// close an open record as truncated, then start fresh
			if (phase_q != PH_WAIT && has_end) begin
				emit      = 1'b1;
				res.trunc = 1'b1;
				if (type_q == REC_EXT_LINEAR)
					addr_n[31:16] = ftb_q;
			end
			addr_n[15:0] = 16'h0000;
			phase_n = PH_CNT_HI;
			hold_n  = '0;
			dcnt_n  = '0;
			rcnt_n  = '0;
			type_n  = '0;
			sum_n   = '0;
			ftb_n   = '0;
		end else if (dig.ok) begin
			case (phase_q)
				PH_CNT_HI: begin
					hold_n  = dig.val;
					phase_n = PH_CNT_LO;
				end
				PH_CNT_LO: begin
					dcnt_n  = byte_val;
					sum_n   = sum_add;
					phase_n = PH_ADRH_HI;
				end
				PH_ADRH_HI: begin
					hold_n  = dig.val;
					phase_n = PH_ADRH_LO;
				end
				PH_ADRH_LO: begin
					addr_n  = {addr_q[31:16], byte_val, 8'h00};
					sum_n   = sum_add;
					phase_n = PH_ADRL_HI;
				end
				PH_ADRL_HI: begin
					hold_n  = dig.val;
					phase_n = PH_ADRL_LO;
				end
				PH_ADRL_LO: begin
					addr_n  = {addr_q[31:8], addr_q[7:0] | byte_val};
					sum_n   = sum_add;
					phase_n = PH_TYPE_HI;
				end
				PH_TYPE_HI: begin
					hold_n  = dig.val;
					phase_n = PH_TYPE_LO;
				end
				PH_TYPE_LO: begin
					// types above 7 drop the record
					if (byte_val > REC_TYPE_MAX) begin
						phase_n = PH_WAIT;
					end else begin
						type_n  = byte_val[2:0];
						sum_n   = sum_add;
						phase_n = PH_DATA_HI;
					end
				end
				PH_DATA_HI: begin
					hold_n  = dig.val;
					phase_n = PH_DATA_LO;
				end
				PH_DATA_LO: begin
					sum_n = sum_add;
					if (rcnt_q < dcnt_q) begin
						// data byte
						if (rcnt_q == 8'd0)
							ftb_n[15:8] = byte_val;
						else if (rcnt_q == 8'd1)
							ftb_n[7:0] = byte_val;
						rcnt_n   = rcnt_q + 8'd1;
						emit     = 1'b1;
						res.kind = KIND_DATA;
						res.idx  = rcnt_q;
						res.data = byte_val;
						res.len  = rcnt_q + 8'd1;
						phase_n  = PH_DATA_HI;
					end else begin
						// checksum byte closes the record
						if (has_end) begin
							emit        = 1'b1;
							res.csum_ok = (sum_add == 8'd0);
							if (type_q == REC_EXT_LINEAR)
								addr_n[31:16] = ftb_q;
						end
						phase_n = PH_WAIT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			hold_q  <= '0;
			dcnt_q  <= '0;
			rcnt_q  <= '0;
			addr_q  <= '0;
			type_q  <= '0;
			sum_q   <= '0;
			ftb_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			hold_q  <= hold_n;
			dcnt_q  <= dcnt_n;
			rcnt_q  <= rcnt_n;
			addr_q  <= addr_n;
			type_q  <= type_n;
			sum_q   <= sum_n;
			ftb_q   <= ftb_n;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/intel_hex_record_decoder_unit.sv
// Intel HEX record decoder: one character in, at most one result out
//
// Input channel (in_valid/in_ready, char_in) takes one ASCII character per
// transaction. Output channel (out_valid/out_ready) delivers a decoded data
// byte (result_kind 0) or an end-of-record summary (result_kind 1).
// Characters that yield no result are consumed silently.
// A result passes through the input register, where its character is captured, and
// the output register, into which it is decoded.
// Throughput: one character per cycle while no result waits on a stalled receiver, set by
// the single decode step between the input register and the output register; the parser
// state updates in the same cycle as the output register.
// Reset (arst_n low) clears the parser to waiting-for-colon, drops both
// registers and clears the upper address.
// While the receiver stalls, a held result keeps its value; characters that
// produce no result keep flowing, and the first one that does produce a
// result waits in the input register, which then deasserts in_ready.
`default_nettype none

module intel_hex_record_decoder_unit import ihexd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             result_kind,
	output logic [2:0]       record_type,
	output logic [31:0]      record_address,
	output logic [7:0]       byte_index,
	output logic [7:0]       data_value,
	output logic [7:0]       record_length,
	output logic             checksum_ok,
	output logic             truncated
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_valid_s2;
	result_t    res_s2;

	logic       emit;
	result_t    res;
	logic       adv_s1;

	// Stage 1 moves when it has no result or the output slot frees up
	assign adv_s1   = valid_s1 && (!emit || !out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	ihexd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.char_in (char_s1),
		.emit    (emit),
		.res     (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			char_s1 <= char_in;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit)
			res_s2 <= res;
	end

	assign out_valid      = out_valid_s2;
	assign result_kind    = res_s2.kind;
	assign record_type    = res_s2.rtype;
	assign record_address = res_s2.addr;
	assign byte_index     = res_s2.idx;
	assign data_value     = res_s2.data;
	assign record_length  = res_s2.len;
	assign checksum_ok    = res_s2.csum_ok;
	assign truncated      = res_s2.trunc;

endmodule

`default_nettype wire

// File: hw/rtl/ihexd_chk.sv
// Port-level checker for the Intel HEX record decoder, bound to the top level
`default_nettype none

`include "intel_hex_record_decoder_unit_assert.svh"

module ihexd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        result_kind,
	input wire logic [2:0]  record_type,
	input wire logic [31:0] record_address,
	input wire logic [7:0]  byte_index,
	input wire logic [7:0]  data_value,
	input wire logic [7:0]  record_length,
	input wire logic        checksum_ok,
	input wire logic        truncated
);

	// Stalled result holds
	`IHEXD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(record_address) && $stable(data_value) && $stable(record_length))

	// Input only stalls behind a result the receiver is holding off
	`IHEXD_ASSERT_NOW(a_in_stall, clk, arst_n, !in_ready, out_valid && !out_ready)

	// Data transactions carry no end flags
	`IHEXD_ASSERT_NOW(a_data_flags, clk, arst_n, out_valid && !result_kind, !checksum_ok && !truncated)

	// Data byte count runs one ahead of its index
	`IHEXD_ASSERT_NOW(a_data_len, clk, arst_n, out_valid && !result_kind, record_length == byte_index + 8'd1)

	// End transactions: truncated never passes checksum, no payload byte
	`IHEXD_ASSERT_NOW(a_end_fields, clk, arst_n, out_valid && result_kind, !(truncated && checksum_ok) && byte_index == 8'd0 && data_value == 8'd0)

endmodule

bind intel_hex_record_decoder_unit ihexd_chk u_ihexd_chk (.*);

`default_nettype wire

// File: test/testbench.sv
// Testbench for the Intel HEX record decoder: streams hex text and checks every decoded result
`timescale 1ns / 1ps

module testbench;
	import ihexd_pkg::*;

	// Parser phases of the expected-result model
	localparam logic [3:0] PH_WAIT       = 4'd0;
	localparam logic [3:0] PH_COUNT_HI   = 4'd1;
	localparam logic [3:0] PH_COUNT_LO   = 4'd2;
	localparam logic [3:0] PH_ADDR_HI_LO = 4'd4;
	localparam logic [3:0] PH_ADDR_LO_LO = 4'd6;
	localparam logic [3:0] PH_TYPE_LO    = 4'd8;
	localparam logic [3:0] PH_DATA_HI    = 4'd9;
	localparam logic [3:0] PH_DATA_LO    = 4'd10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_in = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        result_kind;
	logic [2:0]  record_type;
	logic [31:0] record_address;
	logic [7:0]  byte_index;
	logic [7:0]  data_value;
	logic [7:0]  record_length;
	logic        checksum_ok;
	logic        truncated;

	logic [7:0] hex_text[$];
	result_t    pending_results[$];
	int         errors = 0;
	int         stim_chars = 0;
	int         in_gap = 0, in_calm = 0, out_hold = 0, out_calm = 0;

	// Decoder state as the expected-result model sees it
	logic [3:0]  st_phase = PH_WAIT;
	logic [3:0]  st_nibble = '0;
	logic [7:0]  st_count = '0;
	logic [7:0]  st_rcvd = '0;
	logic [31:0] st_addr = '0;
	logic [2:0]  st_type = '0;
	logic [7:0]  st_sum = '0;
	logic [15:0] st_first = '0;

	intel_hex_record_decoder_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_in        (char_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.record_type    (record_type),
		.record_address (record_address),
		.byte_index     (byte_index),
		.data_value     (data_value),
		.record_length  (record_length),
		.checksum_ok    (checksum_ok),
		.truncated      (truncated)
	);

	always #5 clk = ~clk;

	// -1 for anything that is not a hex digit
	function automatic int nibble_of(input logic [7:0] c);
		if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
		if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
		if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
		return -1;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a run with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < 40)
			$display("%0t ERROR %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string field, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0h, expected %0h", field, got, want));
	endtask

	task automatic push_result(input logic kind, input logic [7:0] idx, input logic [7:0] data,
			input logic ok, input logic trunc);
		result_t r;
		r.kind    = kind;
		r.rtype   = st_type;
		r.addr    = st_addr;
		r.idx     = idx;
		r.data    = data;
		r.len     = st_rcvd;
		r.csum_ok = ok;
		r.trunc   = trunc;
		pending_results.push_back(r);
	endtask

	// Close the open record; empty data records report nothing
	task automatic close_record(input logic trunc);
		if (!(st_rcvd == 8'd0 && st_type == REC_DATA)) begin
			push_result(KIND_END, 8'd0, 8'd0, !trunc && st_sum == 8'd0, trunc);
			if (st_type == REC_EXT_LINEAR)
				st_addr[31:16] = st_first;
		end
		st_phase = PH_WAIT;
	endtask

	task automatic open_record();
		st_phase       = PH_COUNT_HI;
		st_nibble      = '0;
		st_count       = '0;
		st_rcvd        = '0;
		st_type        = '0;
		st_sum         = '0;
		st_first       = '0;
		st_addr[15:0]  = '0;
	endtask

	// Advance the model by one accepted character
	task automatic decode_char(input logic [7:0] c);
		int v;
		logic [7:0] b;
		if (c == CHAR_COLON) begin
			if (st_phase != PH_WAIT)
				close_record(1'b1);
			open_record();
			return;
		end
		v = nibble_of(c);
		if (v < 0 || st_phase == PH_WAIT || st_phase > PH_DATA_LO)
			return;
		if (st_phase[0]) begin
			st_nibble = v[3:0];
			st_phase++;
			return;
		end
		b = {st_nibble, v[3:0]};
		case (st_phase)
			PH_COUNT_LO: st_count = b;
			PH_ADDR_HI_LO: st_addr[15:0] = {b, 8'h00};
			PH_ADDR_LO_LO: st_addr[7:0] = b;
			PH_TYPE_LO: begin
				if (b > REC_TYPE_MAX) begin
					st_phase = PH_WAIT;
					return;
				end
				st_type = b[2:0];
			end
			default: begin
				// data byte, or checksum once the count is reached
				st_sum += b;
				if (st_rcvd < st_count) begin
					if (st_rcvd == 8'd0)
						st_first[15:8] = b;
					else if (st_rcvd == 8'd1)
						st_first[7:0] = b;
					st_rcvd++;
					push_result(KIND_DATA, st_rcvd - 8'd1, b, 1'b0, 1'b0);
					st_phase = PH_DATA_HI;
				end else begin
					close_record(1'b0);
				end
				return;
			end
		endcase
		st_sum += b;
		st_phase++;
	endtask

	// ---- stimulus building ----

	task automatic put_char(input logic [7:0] c);
		hex_text.push_back(c);
		if (c == CHAR_COLON || nibble_of(c) >= 0)
			stim_chars++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return CHAR_0 + 8'(n);
		return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CHAR_COLON || nibble_of(c) >= 0);
		return c;
	endfunction

	function automatic logic [7:0] pick_data();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// One record; fill < 0 gives random data, cut >= 0 stops after that many digits
	task automatic emit_record(input logic [7:0] count, input logic [15:0] addr,
			input logic [7:0] rtype, input int fill, input bit bad_sum, input int cut);
		logic [7:0] rec[$];
		logic [7:0] sum;
		int nib;
		rec = '{count, addr[15:8], addr[7:0], rtype};
		for (int i = 0; i < count; i++)
			rec.push_back(fill < 0 ? pick_data() : 8'(fill));
		sum = '0;
		foreach (rec[i])
			sum += rec[i];
		sum = 8'h00 - sum;
		if (bad_sum)
			sum += 8'($urandom_range(1, 255));
		rec.push_back(sum);
		put_char(CHAR_COLON);
		nib = 0;
		foreach (rec[i]) begin
			for (int h = 1; h >= 0; h--) begin
				if (cut >= 0 && nib >= cut)
					return;
				put_char(hex_char(h ? rec[i][7:4] : rec[i][3:0]));
				nib++;
				if ($urandom_range(0, 39) == 0)
					put_char(noise_char());
			end
		end
	endtask

	function automatic logic [15:0] pick_addr();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'h0000;
		if (r == 1) return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	// ---- input side ----
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (hex_text.size() != 0) begin
				char_in  <= hex_text.pop_front();
				in_valid <= 1'b1;
				in_gap = pick_gap(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---- output side back-pressure ----
	always @(posedge clk) begin
		int g;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			g = pick_gap(out_calm);
			out_ready <= (g == 0);
			out_hold = (g > 0) ? g - 1 : 0;
		end else if ($urandom_range(0, 15) == 0) begin
			out_ready <= 1'b0;
			out_hold = $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ---- monitor: check the result transaction, then model the input transaction ----
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no expected result pending");
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", result_kind, want.kind);
					check_field("record_type", record_type, want.rtype);
					check_field("record_address", record_address, want.addr);
					check_field("byte_index", byte_index, want.idx);
					check_field("data_value", data_value, want.data);
					check_field("record_length", record_length, want.len);
					check_field("checksum_ok", checksum_ok, want.csum_ok);
					check_field("truncated", truncated, want.trunc);
				end
			end
			if (in_valid && in_ready)
				decode_char(char_in);
		end
	end

	// ---- stimulus and end of run ----
	initial begin
		int r;
		int big_left;
		int cnt;
		big_left = 3;

		// directed: ignored characters and digits while waiting
		put_char(8'h00);
		put_char(8'hFF);
		put_char(CHAR_0 + 8'd1);
		put_char(CHAR_LF);
		// full record at the top address, data byte extremes
		emit_record(8'd1, 16'hFFFF, 8'd0, 8'hFF, 1'b0, -1);
		emit_record(8'd2, 16'h0000, 8'd0, 8'h00, 1'b0, -1);
		// upper address from an extended linear record, then used
		emit_record(8'd2, 16'h0000, 8'd4, 8'hFF, 1'b0, -1);
		emit_record(8'd1, 16'h1234, 8'd0, -1, 1'b0, -1);
		// empty data record, end-of-file record, type 7, type 8 skipped
		emit_record(8'd0, 16'h0000, 8'd0, -1, 1'b0, -1);
		emit_record(8'd0, 16'h0000, 8'd1, -1, 1'b0, -1);
		emit_record(8'd3, 16'hABCD, 8'd7, -1, 1'b0, -1);
		emit_record(8'd3, 16'hABCD, 8'd8, -1, 1'b0, -1);
		// bad checksum, then a record cut off after two data bytes
		emit_record(8'd2, 16'h5555, 8'd0, -1, 1'b1, -1);
		emit_record(8'd4, 16'hAAAA, 8'd0, -1, 1'b0, 12);
		// extended linear record cut off after one data byte, colon right after colon
		emit_record(8'd2, 16'h0000, 8'd4, -1, 1'b0, 10);
		put_char(CHAR_COLON);
		emit_record(8'd1, 16'h0F0F, 8'd0, -1, 1'b0, -1);

		// random text, mostly well-formed records
		stim_chars = 0;
		while (stim_chars < 1400) begin
			r = $urandom_range(0, 99);
			cnt = $urandom_range(0, 9) == 0 ? $urandom_range(17, 64) : $urandom_range(1, 16);
			if (r == 0 && big_left > 0) begin
				cnt = (big_left == 1) ? 255 : $urandom_range(128, 254);
				big_left--;
				emit_record(8'(cnt), pick_addr(), 8'd0, -1, 1'b0, -1);
			end else if (r < 55)
				emit_record(8'(cnt), pick_addr(), 8'd0, -1, 1'b0, -1);
			else if (r < 62)
				emit_record(8'($urandom_range(0, 6)), pick_addr(), 8'($urandom_range(0, 7)), -1,
					1'b0, -1);
			else if (r < 68)
				emit_record($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 3)) : 8'd2,
					pick_addr(), 8'd4, -1, 1'b0, -1);
			else if (r < 74)
				emit_record(8'(cnt), pick_addr(), 8'($urandom_range(0, 7)), -1, 1'b1, -1);
			else if (r < 82)
				emit_record(8'(cnt), pick_addr(), 8'($urandom_range(0, 7)), -1, 1'b0,
					$urandom_range(0, 2 * cnt + 9));
			else if (r < 86)
				emit_record(8'(cnt), pick_addr(), 8'($urandom_range(8, 255)), -1, 1'b0, -1);
			else if (r < 89)
				emit_record(8'd0, pick_addr(), 8'd0, -1, 1'b0,
					$urandom_range(0, 1) ? -1 : $urandom_range(0, 9));
			else if (r < 94) begin
				repeat ($urandom_range(1, 6))
					put_char(noise_char());
			end else begin
				// stray digits after a record has ended
				repeat ($urandom_range(1, 6))
					put_char(hex_char(4'($urandom_range(0, 15))));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (hex_text.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_results.size()));
		if (errors == 0)
			$display("intel_hex_record_decoder_unit test passed");
		else
			$display("intel_hex_record_decoder_unit test failed");
		$finish;
	end

	// Run limit
	initial begin
		#8_000_000;
		$display("intel_hex_record_decoder_unit test failed");
		$finish;
	end

endmodule

// File: intel_hex_record_decoder_unit.f
+incdir+hw/rtl
hw/rtl/ihexd_pkg.sv
hw/rtl/ihexd_core.sv
hw/rtl/intel_hex_record_decoder_unit.sv
hw/rtl/ihexd_chk.sv
test/testbench.sv
